[hdl/ympd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ympd_pkg
// Shared types, codes and the CRC-16/XMODEM byte step for the YMODEM deframer.
// ----------------------------------------------------------------------------
package ympd_pkg;

  localparam int unsigned CFG_W   = 24;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [CFG_W-1:0] CFG_TIMEOUT_RESET = 24'd100000;
  localparam logic [15:0]      CRC_POLY          = 16'h1021;

  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_EOT   = 8'h04;
  localparam logic [7:0] BYTE_CA    = 8'h18;
  localparam logic [7:0] BYTE_ABT_U = 8'h41;
  localparam logic [7:0] BYTE_ABT_L = 8'h61;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EOT    = 3'd1;
  localparam logic [2:0] ST_CANCEL = 3'd2;
  localparam logic [2:0] ST_ABORT  = 3'd3;
  localparam logic [2:0] ST_ERROR  = 3'd4;

  typedef enum logic [2:0] {
    CMD_SEQ,
    CMD_COMP,
    CMD_DATA,
    CMD_CRCH,
    CMD_CRCL,
    CMD_STAT
  } cmd_e;

  // data carries the byte, or the status code for CMD_STAT
  typedef struct packed {
    cmd_e       code;
    logic [7:0] data;
    logic       long_blk;
  } cmd_t;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/ympd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ympd_front
// Header decode, packet phase tracking and byte timeout; issues commands.
// ----------------------------------------------------------------------------
module ympd_front import ympd_pkg::*; #(
  parameter int unsigned SHORT_BLOCK  = 128,
  parameter int unsigned LONG_BLOCK   = 1024,
  parameter int unsigned TIMEOUT_BITS = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             in_accept_i,
  input  wire logic             in_mode_i,
  input  wire logic [7:0]       in_byte_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  localparam int unsigned MAX_BLK = (SHORT_BLOCK > LONG_BLOCK) ? SHORT_BLOCK : LONG_BLOCK;
  localparam int unsigned IDX_W   = $clog2(MAX_BLK);
  localparam int unsigned CMP_W   = (TIMEOUT_BITS > CFG_W) ? TIMEOUT_BITS : CFG_W;
  localparam logic [IDX_W:0] SHORT_LEN = (IDX_W+1)'(SHORT_BLOCK);
  localparam logic [IDX_W:0] LONG_LEN  = (IDX_W+1)'(LONG_BLOCK);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CANCEL = 3'd1;
  localparam logic [2:0] PH_SEQ    = 3'd2;
  localparam logic [2:0] PH_COMP   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CRCH   = 3'd5;
  localparam logic [2:0] PH_CRCL   = 3'd6;

  logic [CFG_W-1:0]        timeout_q;
  logic [2:0]              phase_q, phase_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    long_q, long_d;
  logic [TIMEOUT_BITS-1:0] tick_q, tick_d;
  logic [IDX_W:0]          idx_inc;
  logic [IDX_W:0]          blen;

  assign idx_inc = {1'b0, idx_q} + (IDX_W+1)'(1);
  assign blen    = long_q ? LONG_LEN : SHORT_LEN;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    long_d  = long_q;
    tick_d  = tick_q;
    push_o  = 1'b0;
    cmd_o   = '{code: CMD_STAT, data: 8'h00, long_blk: long_q};
    if (in_accept_i) begin
      if (in_mode_i) begin
        tick_d = tick_q + TIMEOUT_BITS'(1);
        if (CMP_W'(tick_d) >= CMP_W'(timeout_q)) begin
          tick_d     = '0;
          push_o     = 1'b1;
          cmd_o.data = {5'd0, ST_ERROR};
          phase_d    = PH_IDLE;
          idx_d      = '0;
        end
      end else begin
        tick_d     = '0;
        cmd_o.data = in_byte_i;
        case (phase_q)
          PH_IDLE: begin
            if (in_byte_i == BYTE_SOH || in_byte_i == BYTE_STX) begin
              long_d  = (in_byte_i == BYTE_STX);
              idx_d   = '0;
              phase_d = PH_SEQ;
            end else if (in_byte_i == BYTE_CA) begin
              phase_d = PH_CANCEL;
            end else begin
              push_o = 1'b1;
              idx_d  = '0;
              if (in_byte_i == BYTE_EOT) begin
                cmd_o.data = {5'd0, ST_EOT};
              end else if (in_byte_i == BYTE_ABT_U || in_byte_i == BYTE_ABT_L) begin
                cmd_o.data = {5'd0, ST_ABORT};
              end else begin
                cmd_o.data = {5'd0, ST_ERROR};
              end
            end
          end
          PH_CANCEL: begin
            push_o     = 1'b1;
            cmd_o.data = (in_byte_i == BYTE_CA) ? {5'd0, ST_CANCEL} : {5'd0, ST_ERROR};
            phase_d    = PH_IDLE;
            idx_d      = '0;
          end
          PH_SEQ: begin
            push_o     = 1'b1;
            cmd_o.code = CMD_SEQ;
            phase_d    = PH_COMP;
          end
          PH_COMP: begin
            push_o     = 1'b1;
            cmd_o.code = CMD_COMP;
            idx_d      = '0;
            phase_d    = PH_DATA;
          end
          PH_DATA: begin
            push_o     = 1'b1;
            cmd_o.code = CMD_DATA;
            if (idx_inc >= blen) begin
              idx_d   = '0;
              phase_d = PH_CRCH;
            end else begin
              idx_d = idx_inc[IDX_W-1:0];
            end
          end
          PH_CRCH: begin
            push_o     = 1'b1;
            cmd_o.code = CMD_CRCH;
            phase_d    = PH_CRCL;
          end
          PH_CRCL: begin
            push_o     = 1'b1;
            cmd_o.code = CMD_CRCL;
            phase_d    = PH_IDLE;
            idx_d      = '0;
          end
          default: begin
            phase_d = PH_IDLE;
            idx_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= CFG_TIMEOUT_RESET;
      phase_q   <= PH_IDLE;
      idx_q     <= '0;
      long_q    <= 1'b0;
      tick_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      idx_q   <= idx_d;
      long_q  <= long_d;
      tick_q  <= tick_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept_i && in_mode_i && push_o) |=> (tick_q == '0 && phase_q == PH_IDLE))
    else $error("timeout did not return to idle");
`endif

endmodule
`default_nettype wire

[hdl/ympd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ympd_fifo
// Small command queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module ympd_fifo import ympd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count overflow");
  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into full queue");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");
`endif

endmodule
`default_nettype wire

[hdl/ympd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ympd_back
// Executes commands: CRC over payload, sequence check, result beat register.
// ----------------------------------------------------------------------------
module ympd_back import ympd_pkg::*; #(
  parameter int unsigned SHORT_BLOCK = 128,
  parameter int unsigned LONG_BLOCK  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_kind_o,
  output logic [7:0]       out_payload_o,
  output logic [2:0]       out_status_o,
  output logic [LEN_W-1:0] out_len_o,
  output logic [7:0]       out_seq_o
);

  logic [15:0]      crc_q;
  logic [7:0]       seq_q, comp_q, crch_q;
  logic             vld_q;
  logic             kind_q;
  logic [7:0]       pay_q, oseq_q;
  logic [2:0]       stat_q;
  logic [LEN_W-1:0] len_q;
  logic             emits, space, ok;

  assign emits = (cmd_i.code == CMD_DATA) || (cmd_i.code == CMD_CRCL) ||
                 (cmd_i.code == CMD_STAT);
  assign space = !vld_q || out_ready_i;
  assign cmd_pop_o = cmd_valid_i && (!emits || space);
  assign ok = ({crch_q, cmd_i.data} == crc_q) && (seq_q == ~comp_q);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      case (cmd_i.code)
        CMD_SEQ: begin
          seq_q <= cmd_i.data;
          crc_q <= '0;
        end
        CMD_COMP: comp_q <= cmd_i.data;
        CMD_DATA: begin
          crc_q  <= crc16_step(crc_q, cmd_i.data);
          kind_q <= 1'b0;
          pay_q  <= cmd_i.data;
          stat_q <= ST_OK;
          len_q  <= '0;
          oseq_q <= '0;
        end
        CMD_CRCH: crch_q <= cmd_i.data;
        CMD_CRCL: begin
          kind_q <= 1'b1;
          pay_q  <= '0;
          stat_q <= ok ? ST_OK : ST_ERROR;
          len_q  <= !ok ? '0 : (cmd_i.long_blk ? LEN_W'(LONG_BLOCK) : LEN_W'(SHORT_BLOCK));
          oseq_q <= ok ? seq_q : '0;
        end
        default: begin
          kind_q <= 1'b1;
          pay_q  <= '0;
          stat_q <= cmd_i.data[2:0];
          len_q  <= '0;
          oseq_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_pop_o && emits) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_kind_o    = kind_q;
  assign out_payload_o = pay_q;
  assign out_status_o  = stat_q;
  assign out_len_o     = len_q;
  assign out_seq_o     = oseq_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |-> !(cmd_pop_o && emits))
    else $error("pending result overwritten");
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !kind_q) |-> (stat_q == ST_OK && len_q == '0 && oseq_q == '0))
    else $error("payload beat carries status fields");
`endif

endmodule
`default_nettype wire

[hdl/ymodem_packet_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ymodem_packet_deframer
// YMODEM packet receiver with CRC-16/XMODEM check and byte timeout.
// ----------------------------------------------------------------------------
// Input stream: one beat per received byte (tuser 0, byte in tdata) or per
// timer tick (tuser 1). Output stream: payload bytes (tuser 0) as they
// arrive, then one status beat (tuser 1) per packet, control byte or timeout.
// A beat can be taken every cycle while the command queue is not full.
// A result passes from the classifier into the 4-entry command queue,
// then through the execute stage into the output register.
// Sustained rate is one input beat per cycle while the output is drained.
// When the output stalls, the queue absorbs up to four commands; after that
// s_axis_tready drops until the output register frees up.
// Reset: idle awaiting a header, tick count zero, byte timeout 100000 ticks,
// queue and output register empty. cfg_we_i loads the timeout register.
// ----------------------------------------------------------------------------
module ymodem_packet_deframer import ympd_pkg::*; #(
  parameter int unsigned SHORT_BLOCK  = 128,
  parameter int unsigned LONG_BLOCK   = 1024,
  parameter int unsigned TIMEOUT_BITS = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  input  wire logic             s_axis_tuser,   // [0] mode
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                                // [21:11] pkt_len, [29:22] sequence_res
  output logic                  m_axis_tuser    // [0] kind
);

  logic             in_accept;
  logic             push;
  cmd_t             push_cmd;
  logic             q_full, q_valid, q_pop;
  cmd_t             q_cmd;
  logic [7:0]       o_payload, o_seq;
  logic [2:0]       o_status;
  logic [LEN_W-1:0] o_len;

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && !q_full;

  ympd_front #(
    .SHORT_BLOCK  (SHORT_BLOCK),
    .LONG_BLOCK   (LONG_BLOCK),
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_accept_i (in_accept),
    .in_mode_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ympd_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  ympd_back #(
    .SHORT_BLOCK (SHORT_BLOCK),
    .LONG_BLOCK  (LONG_BLOCK)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_payload_o (o_payload),
    .out_status_o  (o_status),
    .out_len_o     (o_len),
    .out_seq_o     (o_seq)
  );

  assign m_axis_tdata = {2'b00, o_seq, o_len, o_status, o_payload};

endmodule
`default_nettype wire
